/* hw/rtl/cmas_pkg.sv */
// ----------------------------------------------------------------------------
// Complex matrix absolute sums package
// Shared constants, state types and helper functions for the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmas_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 4096;
  localparam int SUM_W      = 48;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int IDX_W      = 12;
  localparam int ELEM_W     = 32;
  localparam int MAG_W      = 32;
  localparam int RAD_W      = 2 * ELEM_W;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int STEP_W     = $clog2(ROOT_STEPS);
  localparam int RCNT_W     = 7;
  localparam int CCNT_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_PAD_W  = OUT_DATA_W - SUM_W - IDX_W;

  localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd2;

  localparam logic MODE_COL = 1'b0;
  localparam logic MODE_ROW = 1'b1;

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [MAG_W-1:0] mag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_COL,
    ST_RD,
    ST_LD
  } top_state_e;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_SQ_RE,
    MS_SQ_IM,
    MS_SUM,
    MS_ROOT,
    MS_DONE
  } mag_state_e;

  function automatic logic [RCNT_W-1:0] eff_rows(input logic [RCNT_W-1:0] cnt);
    logic [RCNT_W-1:0] res;
    if (cnt == '0) begin
      res = RCNT_W'(1);
    end else if (cnt > RCNT_W'(MAX_ROWS)) begin
      res = RCNT_W'(MAX_ROWS);
    end else begin
      res = cnt;
    end
    return res;
  endfunction

  function automatic logic [CCNT_W-1:0] eff_cols(input logic [CCNT_W-1:0] cnt);
    logic [CCNT_W-1:0] res;
    if (cnt == '0) begin
      res = CCNT_W'(1);
    end else if (cnt > CCNT_W'(MAX_COLS)) begin
      res = CCNT_W'(MAX_COLS);
    end else begin
      res = cnt;
    end
    return res;
  endfunction

  function automatic sum_t sat_add(input sum_t acc, input mag_t mag);
    logic [SUM_W:0] full;
    full = {1'b0, acc} + {{(SUM_W + 1 - MAG_W){1'b0}}, mag};
    return full[SUM_W] ? '1 : full[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cmas_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmas_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/cmas_mag.sv */
// ----------------------------------------------------------------------------
// Complex magnitude unit
// Squares both components on one shared multiplier, then takes the floor
// square root of their sum one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmas_mag
  import cmas_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [ELEM_W-1:0] re_i,
  input  wire logic signed [ELEM_W-1:0] im_i,
  output logic                          done_o,
  output mag_t                          mag_o
);

  mag_state_e state_q, state_d;

  logic [ELEM_W-1:0] are_q, aim_q;
  logic [ELEM_W-1:0] abs_re, abs_im, mul_op;
  logic [RAD_W-1:0]  prod, prod_q, x_q, res_q, bit_q, trial;
  logic [STEP_W-1:0] step_q;

  assign abs_re = re_i[ELEM_W-1] ? (~re_i + 1'b1) : re_i;
  assign abs_im = im_i[ELEM_W-1] ? (~im_i + 1'b1) : im_i;
  assign mul_op = (state_q == MS_SQ_RE) ? are_q : aim_q;
  assign prod   = {{ELEM_W{1'b0}}, mul_op} * {{ELEM_W{1'b0}}, mul_op};
  assign trial  = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      MS_IDLE: begin
        if (start_i) begin
          state_d = MS_SQ_RE;
        end
      end
      MS_SQ_RE: state_d = MS_SQ_IM;
      MS_SQ_IM: state_d = MS_SUM;
      MS_SUM:   state_d = MS_ROOT;
      MS_ROOT: begin
        if (step_q == '0) begin
          state_d = MS_DONE;
        end
      end
      MS_DONE:  state_d = MS_IDLE;
      default:  state_d = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MS_IDLE: begin
        if (start_i) begin
          are_q <= abs_re;
          aim_q <= abs_im;
        end
      end
      MS_SQ_RE: prod_q <= prod;
      MS_SQ_IM: begin
        x_q    <= prod_q;
        prod_q <= prod;
      end
      MS_SUM: begin
        x_q    <= x_q + prod_q;
        res_q  <= '0;
        bit_q  <= {2'b01, {(RAD_W - 2){1'b0}}};
        step_q <= STEP_W'(ROOT_STEPS - 1);
      end
      MS_ROOT: begin
        if (x_q >= trial) begin
          x_q   <= x_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q  <= bit_q >> 2;
        step_q <= step_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign done_o = (state_q == MS_DONE);
  assign mag_o  = res_q[MAG_W-1:0];

  a_bit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MS_ROOT) |-> $onehot(bit_q))
    else $error("root step bit is not one-hot");

  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MS_DONE) |-> (res_q[RAD_W-1:MAG_W] == '0))
    else $error("root result exceeds magnitude width");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == MS_IDLE))
    else $error("magnitude unit started while busy");

endmodule

`default_nettype wire

/* hw/rtl/complex_matrix_abs_sums.sv */
// ----------------------------------------------------------------------------
// Complex matrix absolute sums
// Sums element magnitudes of a column-major complex matrix per column or
// per row, with saturation, and streams the sums out.
// ----------------------------------------------------------------------------
// An element beat holds the block while the magnitude unit squares both parts on
// the shared multiplier and takes the bit-serial square root, then hands off.
// A column's sum then waits in the column state for a free output slot; after a
// matrix's last element in row mode, each row sum takes a read and a load state.
// Reset restores the register defaults, zeroes positions and marks all row
// sums invalid so that they read as zero.
`timescale 1ns / 1ps
`default_nettype none

module complex_matrix_abs_sums
  import cmas_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Fields from bit 0: real_part[31:0], imag_part[63:32].
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // Fields from bit 0: abs_sum[47:0], sum_index[59:48], zero padding.
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                       m_axis_tlast_o,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  top_state_e state_q, state_d;

  logic              norm_mode_q;
  logic [RCNT_W-1:0] row_count_q, rows_eff;
  logic [CCNT_W-1:0] col_count_q, cols_eff;

  logic [ROW_W-1:0]  row_pos_q, row_pos_d;
  logic [COL_W-1:0]  col_pos_q, col_pos_d;
  sum_t              col_sum_q, col_sum_d;
  logic [COL_W-1:0]  pend_idx_q, pend_idx_d;
  logic              pend_last_q, pend_last_d;
  logic [ROW_W-1:0]  emit_idx_q, emit_idx_d;
  logic [MAX_ROWS-1:0] valid_q, valid_d;

  logic              out_valid_q, out_valid_d;
  sum_t              out_sum_q, out_sum_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;

  logic              cfg_hit, slot_free, end_col, end_mat, first_elem, emit_last;
  logic              mag_start, mag_done;
  mag_t              mag;
  logic              ram_we;
  logic [ROW_W-1:0]  ram_raddr;
  sum_t              ram_rdata, ram_wdata, row_base;

  assign rows_eff   = eff_rows(row_count_q);
  assign cols_eff   = eff_cols(col_count_q);
  assign cfg_hit    = cfg_we_i && ((cfg_idx_i == REG_NORM_MODE) ||
                      (cfg_idx_i == REG_ROW_COUNT) || (cfg_idx_i == REG_COL_COUNT));
  assign slot_free  = !out_valid_q || m_axis_tready_i;
  assign end_col    = ({1'b0, row_pos_q} == rows_eff - 1'b1);
  assign end_mat    = end_col && ({1'b0, col_pos_q} == cols_eff - 1'b1);
  assign first_elem = (row_pos_q == '0) && (col_pos_q == '0);
  assign emit_last  = ({1'b0, emit_idx_q} == rows_eff - 1'b1);
  assign row_base   = (first_elem || !valid_q[row_pos_q]) ? '0 : ram_rdata;
  assign ram_wdata  = sat_add(row_base, mag);
  assign ram_raddr  = ((state_q == ST_RD) || (state_q == ST_LD)) ? emit_idx_q : row_pos_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign mag_start       = s_axis_tvalid_i && s_axis_tready_o;

  cmas_mag u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mag_start),
    .re_i    (s_axis_tdata_i[ELEM_W-1:0]),
    .im_i    (s_axis_tdata_i[2*ELEM_W-1:ELEM_W]),
    .done_o  (mag_done),
    .mag_o   (mag)
  );

  cmas_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_pos_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_mode_q <= MODE_COL;
      row_count_q <= RCNT_W'(1);
      col_count_q <= CCNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NORM_MODE: norm_mode_q <= cfg_wdata_i[0];
        REG_ROW_COUNT: row_count_q <= cfg_wdata_i[RCNT_W-1:0];
        REG_COL_COUNT: col_count_q <= cfg_wdata_i[CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_pos_q   <= '0;
      col_pos_q   <= '0;
      col_sum_q   <= '0;
      emit_idx_q  <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_pos_q   <= row_pos_d;
      col_pos_q   <= col_pos_d;
      col_sum_q   <= col_sum_d;
      emit_idx_q  <= emit_idx_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= pend_idx_d;
    pend_last_q <= pend_last_d;
    out_sum_q   <= out_sum_d;
    out_idx_q   <= out_idx_d;
    out_last_q  <= out_last_d;
  end

  always_comb begin
    state_d     = state_q;
    row_pos_d   = row_pos_q;
    col_pos_d   = col_pos_q;
    col_sum_d   = col_sum_q;
    pend_idx_d  = pend_idx_q;
    pend_last_d = pend_last_q;
    emit_idx_d  = emit_idx_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_sum_d   = out_sum_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (mag_start) begin
          state_d = ST_MAG;
        end
      end
      ST_MAG: begin
        if (mag_done) begin
          if (norm_mode_q == MODE_COL) begin
            col_sum_d = sat_add(col_sum_q, mag);
            if (end_col) begin
              pend_idx_d  = col_pos_q;
              pend_last_d = end_mat;
              state_d     = ST_COL;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            ram_we = 1'b1;
            if (first_elem) begin
              valid_d = '0;
            end
            valid_d[row_pos_q] = 1'b1;
            emit_idx_d = '0;
            state_d    = end_mat ? ST_RD : ST_IDLE;
          end
          if (end_col) begin
            row_pos_d = '0;
            col_pos_d = end_mat ? '0 : col_pos_q + 1'b1;
          end else begin
            row_pos_d = row_pos_q + 1'b1;
          end
        end
      end
      ST_COL: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = col_sum_q;
          out_idx_d   = IDX_W'(pend_idx_q);
          out_last_d  = pend_last_q;
          col_sum_d   = '0;
          state_d     = ST_IDLE;
        end
      end
      ST_RD: state_d = ST_LD;
      ST_LD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = valid_q[emit_idx_q] ? ram_rdata : '0;
          out_idx_d   = IDX_W'(emit_idx_q);
          out_last_d  = emit_last;
          if (emit_last) begin
            state_d = ST_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + 1'b1;
            state_d    = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_hit) begin
      row_pos_d = '0;
      col_pos_d = '0;
      col_sum_d = '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_idx_q, out_sum_q};
  assign m_axis_tlast_o  = out_last_q;

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted again while an element is in progress");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LD) |-> ({1'b0, emit_idx_q} < rows_eff))
    else $error("row emission index beyond row count");

  a_done_in_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_done |-> (state_q == ST_MAG))
    else $error("magnitude finished outside of the wait state");

endmodule

`default_nettype wire
